[hdl/rtp_pkg.sv]
// Shared constants and elaboration-time helpers for the rect_to_polar block.
// Holds sample width, CORDIC depth, pipeline latencies and the arctangent
// step constants. No dependencies.
package rtp_pkg;

   // Sample width of the real, imaginary, magnitude and angle fields
   localparam int SAMPLE_BITS = 16;

   // CORDIC datapath: 64-bit words, angle in radians Q62
   localparam int DATA_W       = 64;
   localparam int CORDIC_ITERS = 62;

   // Normalised vectors have their leading one at this bit
   localparam int NORM_TOP = 60;
   localparam int SHIFT_W  = $clog2(NORM_TOP + 1);

   // pi in Q60 (equals pi/4 in Q62) and 1/pi in Q64
   localparam logic [DATA_W-1:0] PI_Q60     = 64'h3243F6A8885A308D;
   localparam logic [DATA_W-1:0] INV_PI_Q64 = 64'h517CC1B727220A94;

   // Rounding of the scaled phase down to SAMPLE_BITS
   localparam int                ROUND_SHIFT = 63 - SAMPLE_BITS;
   localparam logic [DATA_W-1:0] ROUND_ADD   = 64'(1) << (62 - SAMPLE_BITS);
   localparam logic [DATA_W-1:0] QUARTER     = 64'(1) << (SAMPLE_BITS - 2);
   localparam logic [SAMPLE_BITS-1:0] HALF_TURN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // Stage counts: four front stages, the CORDIC, four scaling stages
   localparam int FRONT_STAGES = 4;
   localparam int SCALE_STAGES = 4;
   localparam int PIPE_STAGES  = FRONT_STAGES + CORDIC_ITERS + SCALE_STAGES;

   // Root is ready after the sum stage, one stage per root bit, and rounding
   localparam int MAG_LAT   = 3 + SAMPLE_BITS + 1;
   localparam int MAG_DELAY = PIPE_STAGES - MAG_LAT;

   // Restoring long division, used only to build constants
   function automatic logic [DATA_W-1:0] long_div(input logic [DATA_W-1:0] num,
                                                  input logic [DATA_W-1:0] den);
      logic [DATA_W:0]   rem;
      logic [DATA_W-1:0] quo;
      rem = '0;
      quo = '0;
      for (int b = DATA_W - 1; b >= 0; b--) begin
         rem = {rem[DATA_W-1:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-step) in radians Q62 by its power series, truncated per term
   function automatic logic [DATA_W-1:0] atan_q62(input int step);
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] term;
      int                e;
      acc = '0;
      if (step == 0) begin
         return PI_Q60;
      end
      for (int k = 0; k < 32; k++) begin
         e = 62 - step * (2 * k + 1);
         if (e >= 0) begin
            term = long_div(64'(1) << e, 64'(2 * k + 1));
            if (k[0]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
      end
      return acc;
   endfunction

endpackage

[hdl/rtp_isqrt.sv]
// Pipelined integer square root with round-to-nearest, one root bit per stage.
// Depends on rtp_pkg for SAMPLE_BITS.
// Each root stage and the rounding register move only on advance.
module rtp_isqrt import rtp_pkg::*; (
   input  logic                       clock,
   input  logic                       advance,
   input  logic [2*SAMPLE_BITS-1:0]   sum_sq,
   output logic [SAMPLE_BITS-1:0]     root
);

   localparam int W = 2 * SAMPLE_BITS + 1;

   logic [W-1:0] rem_ff [SAMPLE_BITS];
   logic [W-1:0] q_ff   [SAMPLE_BITS];
   logic [W-1:0] rem_src [SAMPLE_BITS];
   logic [W-1:0] q_src   [SAMPLE_BITS];
   logic [SAMPLE_BITS-1:0] root_ff;
   logic [SAMPLE_BITS-1:0] root_in;

   for (genvar j = 0; j < SAMPLE_BITS; j++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (2 * SAMPLE_BITS - 2 - 2 * j);

      logic [W-1:0] trial;
      logic         fits;
      logic [W-1:0] rem_in;
      logic [W-1:0] q_in;

      // Feed the first stage from the sum, the rest from the stage before
      if (j == 0) begin : g_first
         assign rem_src[j] = W'(sum_sq);
         assign q_src[j]   = '0;
      end else begin : g_next
         assign rem_src[j] = rem_ff[j-1];
         assign q_src[j]   = q_ff[j-1];
      end

      // Try the next root bit and keep it when the remainder allows
      always_comb begin
         trial  = q_src[j] + BIT;
         fits   = rem_src[j] >= trial;
         rem_in = fits ? rem_src[j] - trial : rem_src[j];
         q_in   = fits ? (q_src[j] >> 1) + BIT : q_src[j] >> 1;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
         end
      end
   end

   // Round up when the remainder exceeds the truncated root
   always_comb begin
      root_in = SAMPLE_BITS'(q_ff[SAMPLE_BITS-1])
              + SAMPLE_BITS'(rem_ff[SAMPLE_BITS-1] > q_ff[SAMPLE_BITS-1]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

[hdl/rtp_cordic.sv]
// Vectoring CORDIC, one micro-rotation per pipeline stage, angle in Q62.
// Depends on rtp_pkg for widths, depth and the arctangent step constants.
// Each rotation stage moves only on advance.
module rtp_cordic import rtp_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic [DATA_W-1:0] x_start,
   input  logic [DATA_W-1:0] y_start,
   output logic [DATA_W-1:0] z_end
);

   logic        [DATA_W-1:0] x_ff [CORDIC_ITERS];
   logic signed [DATA_W-1:0] y_ff [CORDIC_ITERS];
   logic        [DATA_W-1:0] z_ff [CORDIC_ITERS];
   logic        [DATA_W-1:0] x_src [CORDIC_ITERS];
   logic signed [DATA_W-1:0] y_src [CORDIC_ITERS];
   logic        [DATA_W-1:0] z_src [CORDIC_ITERS];

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
      localparam logic [DATA_W-1:0] ATAN_STEP = atan_q62(i);

      logic        [DATA_W-1:0] xs;
      logic signed [DATA_W-1:0] ys;
      logic        [DATA_W-1:0] x_in;
      logic signed [DATA_W-1:0] y_in;
      logic        [DATA_W-1:0] z_in;

      if (i == 0) begin : g_first
         assign x_src[i] = x_start;
         assign y_src[i] = y_start;
         assign z_src[i] = '0;
      end else begin : g_next
         assign x_src[i] = x_ff[i-1];
         assign y_src[i] = y_ff[i-1];
         assign z_src[i] = z_ff[i-1];
      end

      // Rotate towards the real axis; the sign of y picks the direction
      always_comb begin
         xs = x_src[i] >> i;
         ys = y_src[i] >>> i;
         if (!y_src[i][DATA_W-1]) begin
            x_in = x_src[i] + ys;
            y_in = y_src[i] - xs;
            z_in = z_src[i] + ATAN_STEP;
         end else begin
            x_in = x_src[i] - ys;
            y_in = y_src[i] + xs;
            z_in = z_src[i] - ATAN_STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign z_end = z_ff[CORDIC_ITERS-1];

endmodule

[hdl/rtp_scale.sv]
// Scales the Q62 radian angle by 1/pi and rounds it to a quadrant turn count.
// Depends on rtp_pkg for INV_PI_Q64 and the rounding constants.
// Registered in stages A to D, each of which moves only on advance.
module rtp_scale import rtp_pkg::*; (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [DATA_W-1:0]      z,
   output logic [SAMPLE_BITS-1:0] turn
);

   localparam int HW = DATA_W / 2;
   localparam logic [HW-1:0] INV_LO = INV_PI_Q64[HW-1:0];
   localparam logic [HW-1:0] INV_HI = INV_PI_Q64[DATA_W-1:HW];

   logic [DATA_W-1:0] z_clip;
   logic [DATA_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [DATA_W-1:0] ll_in, lh_in, hl_in, hh_in;
   logic [HW+1:0]     mid_ff, mid_in;
   logic [DATA_W-1:0] hsum_ff, hsum_in;
   logic [DATA_W-1:0] u_ff, u_in;
   logic [DATA_W-1:0] rounded;
   logic [SAMPLE_BITS-1:0] turn_ff, turn_in;

   // Stage A: clip a negative residue to zero, form four partial products
   always_comb begin
      z_clip = z[DATA_W-1] ? '0 : z;
      ll_in  = DATA_W'(z_clip[HW-1:0])      * DATA_W'(INV_LO);
      lh_in  = DATA_W'(z_clip[HW-1:0])      * DATA_W'(INV_HI);
      hl_in  = DATA_W'(z_clip[DATA_W-1:HW]) * DATA_W'(INV_LO);
      hh_in  = DATA_W'(z_clip[DATA_W-1:HW]) * DATA_W'(INV_HI);
   end

   // Stage B: gather the middle column and the upper half separately
   always_comb begin
      mid_in  = (HW + 2)'(ll_ff >> HW) + (HW + 2)'(lh_ff[HW-1:0])
              + (HW + 2)'(hl_ff[HW-1:0]);
      hsum_in = hh_ff + (lh_ff >> HW) + (hl_ff >> HW);
   end

   // Stage C: add the carry out of the middle column
   always_comb begin
      u_in = hsum_ff + DATA_W'(mid_ff >> HW);
   end

   // Stage D: round to the output scale and clip to a quarter turn
   always_comb begin
      rounded = (u_ff + ROUND_ADD) >> ROUND_SHIFT;
      turn_in = (rounded > QUARTER) ? SAMPLE_BITS'(QUARTER) : SAMPLE_BITS'(rounded);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         mid_ff  <= mid_in;
         hsum_ff <= hsum_in;
         u_ff    <= u_in;
         turn_ff <= turn_in;
      end
   end

   assign turn = turn_ff;

endmodule

[hdl/rect_to_polar.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_real_part, req_imag_part, req_last_in
// rsp      out        rsp_valid/rsp_stall  rsp_magnitude, rsp_angle, rsp_last_out
//
// One sample per clock is taken while req_stall is low; a result passes the
// four front stages, the 62-stage vectoring CORDIC, four scaling stages and
// the output register. The square root runs alongside.
// Synchronous reset clears only the valid bits, also those of output and skid.
// A stalled result fills the skid register; only then does the whole pipeline
// hold, and req_stall comes straight from that register.
// Depends on rtp_pkg, rtp_isqrt, rtp_cordic and rtp_scale.
module rect_to_polar import rtp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_real_part,
   input  logic signed [SAMPLE_BITS-1:0] req_imag_part,
   input  logic                          req_last_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [SAMPLE_BITS-1:0] rsp_magnitude,
   output logic signed [SAMPLE_BITS-1:0] rsp_angle,
   output logic                          rsp_last_out
);

   typedef struct packed {
      logic xneg;
      logic yneg;
      logic zero;
      logic last;
   } side_type;

   logic advance;

   // Front stage signals
   logic [SAMPLE_BITS-1:0] re_raw, im_raw;
   logic [SAMPLE_BITS-1:0] abs_x_in, abs_y_in;
   side_type               side_in;
   logic [SAMPLE_BITS-1:0] abs_x_ff, abs_y_ff;
   logic [SAMPLE_BITS-1:0] max_in, max_ff;
   logic [2*SAMPLE_BITS-1:0] sq_x_in, sq_y_in, sq_x_ff, sq_y_ff;
   logic [SAMPLE_BITS-1:0] abs_x2_ff, abs_y2_ff;
   logic [SHIFT_W-1:0]     lead;
   logic [SHIFT_W-1:0]     shift_in, shift_ff;
   logic [2*SAMPLE_BITS-1:0] sum_in, sum_ff;
   logic [SAMPLE_BITS-1:0] abs_x3_ff, abs_y3_ff;
   logic [DATA_W-1:0]      x_start_in, y_start_in, x_start_ff, y_start_ff;

   // Valid and sideband lines
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   side_type               side_ff [PIPE_STAGES];

   // Unit outputs and magnitude delay
   logic [DATA_W-1:0]      z_end;
   logic [SAMPLE_BITS-1:0] turn;
   logic [SAMPLE_BITS-1:0] root;
   logic [SAMPLE_BITS-1:0] mag_ff [MAG_DELAY];

   // Result assembly and output registers
   side_type               side_end;
   logic [SAMPLE_BITS-1:0] fold_x, fold_y, angle_end;
   logic                   arrive, take;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic                   out_load, skid_load, skid_drain;
   logic [SAMPLE_BITS-1:0] out_mag_ff, out_ang_ff, skid_mag_ff, skid_ang_ff;
   logic                   out_last_ff, skid_last_ff;

   // Hold everything only while the skid register is occupied
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 1: fold into the first quadrant, note signs and the zero sample
   always_comb begin
      re_raw       = req_real_part;
      im_raw       = req_imag_part;
      side_in.xneg = re_raw[SAMPLE_BITS-1];
      side_in.yneg = im_raw[SAMPLE_BITS-1];
      side_in.zero = (re_raw == '0) && (im_raw == '0);
      side_in.last = req_last_in;
      abs_x_in     = side_in.xneg ? ~re_raw + SAMPLE_BITS'(1) : re_raw;
      abs_y_in     = side_in.yneg ? ~im_raw + SAMPLE_BITS'(1) : im_raw;
   end

   // Stage 2: squares for the magnitude, larger part for normalising
   always_comb begin
      sq_x_in = (2 * SAMPLE_BITS)'(abs_x_ff) * (2 * SAMPLE_BITS)'(abs_x_ff);
      sq_y_in = (2 * SAMPLE_BITS)'(abs_y_ff) * (2 * SAMPLE_BITS)'(abs_y_ff);
      max_in  = (abs_x_ff > abs_y_ff) ? abs_x_ff : abs_y_ff;
   end

   // Stage 3: sum of squares, shift that puts the leading one at NORM_TOP
   always_comb begin
      lead = '0;
      for (int i = 0; i < SAMPLE_BITS; i++) begin
         if (max_ff[i]) begin
            lead = SHIFT_W'(i);
         end
      end
      shift_in = SHIFT_W'(NORM_TOP) - lead;
      sum_in   = sq_x_ff + sq_y_ff;
   end

   // Stage 4: normalised vector for the CORDIC
   always_comb begin
      x_start_in = DATA_W'(abs_x3_ff) << shift_ff;
      y_start_in = DATA_W'(abs_y3_ff) << shift_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_x_ff   <= abs_x_in;
         abs_y_ff   <= abs_y_in;
         sq_x_ff    <= sq_x_in;
         sq_y_ff    <= sq_y_in;
         max_ff     <= max_in;
         abs_x2_ff  <= abs_x_ff;
         abs_y2_ff  <= abs_y_ff;
         sum_ff     <= sum_in;
         shift_ff   <= shift_in;
         abs_x3_ff  <= abs_x2_ff;
         abs_y3_ff  <= abs_y2_ff;
         x_start_ff <= x_start_in;
         y_start_ff <= y_start_in;
      end
   end

   // Advance valid bits alongside the data
   assign valid_in = {valid_ff[PIPE_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Carry signs, zero flag and last flag to the end of the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < PIPE_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   rtp_isqrt u_isqrt (
      .clock   (clock),
      .advance (advance),
      .sum_sq  (sum_ff),
      .root    (root)
   );

   rtp_cordic u_cordic (
      .clock   (clock),
      .advance (advance),
      .x_start (x_start_ff),
      .y_start (y_start_ff),
      .z_end   (z_end)
   );

   rtp_scale u_scale (
      .clock   (clock),
      .advance (advance),
      .z       (z_end),
      .turn    (turn)
   );

   // Delay the magnitude to line up with the angle
   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff[0] <= root;
         for (int k = 1; k < MAG_DELAY; k++) begin
            mag_ff[k] <= mag_ff[k-1];
         end
      end
   end

   // Unfold the quadrant angle into the full circle
   always_comb begin
      side_end  = side_ff[PIPE_STAGES-1];
      fold_x    = side_end.xneg ? HALF_TURN - turn : turn;
      fold_y    = side_end.yneg ? '0 - fold_x : fold_x;
      angle_end = side_end.zero ? '0 : fold_y;
   end

   // Output register with one skid entry behind it
   always_comb begin
      take          = out_valid_ff && !rsp_stall;
      arrive        = advance && valid_ff[PIPE_STAGES-1];
      skid_drain    = skid_valid_ff && take;
      out_load      = !skid_valid_ff && (!out_valid_ff || take);
      skid_load     = !skid_valid_ff && out_valid_ff && !take && arrive;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_drain) begin
         skid_valid_in = 1'b0;
      end else if (out_load) begin
         out_valid_in = arrive;
      end else if (skid_load) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_drain) begin
         out_mag_ff  <= skid_mag_ff;
         out_ang_ff  <= skid_ang_ff;
         out_last_ff <= skid_last_ff;
      end else if (out_load) begin
         out_mag_ff  <= mag_ff[MAG_DELAY-1];
         out_ang_ff  <= angle_end;
         out_last_ff <= side_end.last;
      end
      if (skid_load) begin
         skid_mag_ff  <= mag_ff[MAG_DELAY-1];
         skid_ang_ff  <= angle_end;
         skid_last_ff <= side_end.last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_magnitude = out_mag_ff;
   assign rsp_angle     = out_ang_ff;
   assign rsp_last_out  = out_last_ff;

endmodule

[hdl/rtp_checker.sv]
// Port-level checks for rect_to_polar, attached by the bind below.
// Depends on rtp_pkg for the pipeline depth.
// Tracks samples in flight from the transfers seen on both channels.
module rtp_checker import rtp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_magnitude,
   input logic [SAMPLE_BITS-1:0] rsp_angle,
   input logic                   rsp_last_out
);

   localparam int CAPACITY = PIPE_STAGES + 2;
   localparam int CNT_W    = $clog2(CAPACITY + 2);

   logic             in_xfer, out_xfer;
   logic [CNT_W-1:0] in_flight_ff, in_flight_in;

   // Count transfers in minus transfers out
   always_comb begin
      in_xfer      = req_valid && !req_stall;
      out_xfer     = rsp_valid && !rsp_stall;
      in_flight_in = in_flight_ff + CNT_W'(in_xfer) - CNT_W'(out_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // A held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_magnitude)
                                 && $stable(rsp_angle) && $stable(rsp_last_out))
      else $error("result payload changed while stalled");

   // Reset empties the output side and releases the input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or stall not cleared by reset");

   // No result without a sample behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_flight_ff != '0)
      else $error("result shown with no sample in flight");

   // Input is held back only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // Never more samples inside than pipeline, output and skid registers hold
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= CNT_W'(CAPACITY))
      else $error("more samples in flight than storage");

endmodule

bind rect_to_polar rtp_checker u_rtp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_magnitude (rsp_magnitude),
   .rsp_angle     (rsp_angle),
   .rsp_last_out  (rsp_last_out)
);

[dv/tb.sv]
// Self-checking bench for rect_to_polar: drives complex samples, predicts the
// magnitude and phase with an exact 62-step CORDIC, and checks every result.
// Depends on rtp_pkg and the rect_to_polar RTL.
module tb;
   import rtp_pkg::*;

   localparam logic [63:0] ONE_OVER_PI   = 64'h517CC1B727220A94;
   localparam logic [63:0] QUARTER_TURN0 = 64'h3243F6A8885A308D;
   localparam int          ROT_STEPS     = 62;
   localparam int          IDLE_LIMIT    = 4000;

   typedef struct packed {
      logic        [SAMPLE_BITS-1:0] magnitude;
      logic signed [SAMPLE_BITS-1:0] angle;
      logic                          last;
   } polar_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_real_part;
   logic signed [SAMPLE_BITS-1:0] req_imag_part;
   logic                          req_last_in;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic        [SAMPLE_BITS-1:0] rsp_magnitude;
   logic signed [SAMPLE_BITS-1:0] rsp_angle;
   logic                          rsp_last_out;

   polar_type   pending_polar[$];
   logic [63:0] atan_steps[ROT_STEPS];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          hold_off = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;

   rect_to_polar dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_real_part (req_real_part),
      .req_imag_part (req_imag_part),
      .req_last_in   (req_last_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle     (rsp_angle),
      .rsp_last_out  (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rounded length and rounded phase of one sample, exact to the last bit
   function automatic polar_type to_polar(input logic signed [SAMPLE_BITS-1:0] re,
                                          input logic signed [SAMPLE_BITS-1:0] im,
                                          input logic last);
      logic signed [63:0] re_w;
      logic signed [63:0] im_w;
      logic [63:0]        ax, ay, sum_sq, rem, root, probe;
      logic [63:0]        big, x, y, z, xs, ys, u, ang;
      logic [127:0]       prod;
      int                 shift;
      polar_type          p;
      re_w = re;
      im_w = im;
      ax = (re_w < 0) ? -re_w : re_w;
      ay = (im_w < 0) ? -im_w : im_w;

      // square root by digit pairs, then round up past the half point
      sum_sq = ax * ax + ay * ay;
      rem    = sum_sq;
      root   = '0;
      probe  = 64'd1 << 62;
      while (probe > sum_sq) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      if (rem > root) root = root + 1;

      ang = '0;
      if (ax != 0 || ay != 0) begin
         // normalise so the larger part has its top bit at 60
         big   = (ax > ay) ? ax : ay;
         shift = 0;
         while ((big << shift) < (64'd1 << 60)) shift++;
         x = ax << shift;
         y = ay << shift;
         z = '0;
         // rotate towards the real axis, accumulating the angle in Q62
         for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >> i;
            ys = $signed(y) >>> i;
            if (!y[63]) begin
               x = x + ys;
               y = y - xs;
               z = z + atan_steps[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - atan_steps[i];
            end
         end
         if (z[63]) z = '0;
         // scale radians to half-turn units and round once
         prod = 128'(z) * 128'(ONE_OVER_PI);
         u    = prod[127:64];
         u    = (u + (64'd1 << (62 - SAMPLE_BITS))) >> (63 - SAMPLE_BITS);
         if (u > (64'd1 << (SAMPLE_BITS - 2))) u = 64'd1 << (SAMPLE_BITS - 2);
         // unfold from the first quadrant
         ang = (re < 0) ? (64'd1 << (SAMPLE_BITS - 1)) - u : u;
         if (im < 0) ang = -ang;
      end
      p.magnitude = root[SAMPLE_BITS-1:0];
      p.angle     = ang[SAMPLE_BITS-1:0];
      p.last      = last;
      return p;
   endfunction

   function automatic int next_gap();
      return req_quiet ? 0 : $urandom_range(0, 17);
   endfunction

   // Offer one sample after a gap, hold it until transfer, log its prediction
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                              input logic signed [SAMPLE_BITS-1:0] im,
                              input logic last, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      req_last_in   <= last;
      do @(posedge clock); while (req_stall);
      pending_polar.push_back(to_polar(re, im, last));
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has been checked
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_polar.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Axes, diagonals, most negative values, zero and the plus-pi wrap
   task automatic test_corner_samples();
      send_sample(16'sd0, 16'sd0, 1'b0, next_gap());
      send_sample(-16'sd32768, 16'sd0, 1'b1, next_gap());
      send_sample(-16'sd1, 16'sd0, 1'b0, next_gap());
      send_sample(16'sd32767, 16'sd0, 1'b0, next_gap());
      send_sample(16'sd0, 16'sd32767, 1'b1, next_gap());
      send_sample(16'sd0, -16'sd32768, 1'b0, next_gap());
      send_sample(-16'sd32768, -16'sd32768, 1'b0, next_gap());
      send_sample(16'sd32767, 16'sd32767, 1'b1, next_gap());
      send_sample(-16'sd32768, 16'sd32767, 1'b0, next_gap());
      send_sample(16'sd32767, -16'sd32768, 1'b0, next_gap());
      send_sample(16'sd1, 16'sd0, 1'b0, next_gap());
      send_sample(16'sd0, 16'sd1, 1'b1, next_gap());
      send_sample(16'sd0, -16'sd1, 1'b0, next_gap());
      send_sample(-16'sd1, -16'sd1, 1'b0, next_gap());
      send_sample(16'sd1, 16'sd1, 1'b0, next_gap());
      send_sample(-16'sd1, 16'sd1, 1'b1, next_gap());
      send_sample(16'sd32767, 16'sd1, 1'b0, next_gap());
      send_sample(16'sd32767, -16'sd1, 1'b0, next_gap());
      send_sample(-16'sd32767, 16'sd1, 1'b0, next_gap());
      send_sample(-16'sd32767, -16'sd1, 1'b1, next_gap());
      send_sample(-16'sd32768, -16'sd1, 1'b0, next_gap());
      send_sample(16'sd0, 16'sd0, 1'b1, next_gap());
   endtask

   // Mixed samples: uniform, tiny, extreme, diagonal and lopsided
   task automatic test_random_samples(input int count);
      logic signed [SAMPLE_BITS-1:0] re, im;
      logic signed [SAMPLE_BITS-1:0] picks[6];
      picks = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) req_quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               re = SAMPLE_BITS'($urandom);
               im = SAMPLE_BITS'($urandom);
            end
            4: begin
               re = SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
               im = SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
            end
            5, 6: begin
               re = picks[$urandom_range(0, 5)];
               im = picks[$urandom_range(0, 5)];
            end
            7: begin
               re = SAMPLE_BITS'($urandom);
               im = ($urandom_range(0, 1) != 0) ? re : -re;
            end
            default: begin
               re = SAMPLE_BITS'($urandom);
               im = SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3);
               if ($urandom_range(0, 1) != 0) begin
                  im = re;
                  re = SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3);
               end
            end
         endcase
         send_sample(re, im, $urandom_range(0, 7) == 0, next_gap());
      end
      req_quiet = 1'b0;
   endtask

   // Hold the receiver off while samples stream in back to back
   task automatic test_stall_fill(input int count);
      hold_off = 300;
      for (int n = 0; n < count; n++) begin
         send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                     $urandom_range(0, 7) == 0, 0);
      end
   endtask

   // Pause the sender until the pipeline has emptied, then resume
   task automatic test_pause_drain(input int count);
      for (int round = 0; round < 2; round++) begin
         drain();
         for (int n = 0; n < count; n++) begin
            send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                        n == count - 1, next_gap());
         end
      end
   endtask

   // Receiver: draw a stall per result, apply any requested long hold-off
   initial begin
      int wait_cycles;
      int taken;
      rsp_stall = 1'b0;
      taken     = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            wait_cycles = hold_off;
            hold_off    = 0;
         end else if (rsp_quiet) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 17);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
         if (taken % 40 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         @(negedge clock);
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      polar_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_polar.size() == 0) begin
            $error("unexpected result: magnitude %0d angle %0d last_out %0b",
                   rsp_magnitude, rsp_angle, rsp_last_out);
            fail_count++;
         end else begin
            want = pending_polar.pop_front();
            if (rsp_magnitude !== want.magnitude) begin
               $error("magnitude: expected %0d, actual %0d", want.magnitude, rsp_magnitude);
               fail_count++;
            end
            if (rsp_angle !== want.angle) begin
               $error("angle: expected %0d, actual %0d", want.angle, rsp_angle);
               fail_count++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out: expected %0b, actual %0b", want.last, rsp_last_out);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run after a long stretch with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] acc;
      logic [63:0] term;
      int          k;
      int          e;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_real_part = '0;
      req_imag_part = '0;
      req_last_in   = 1'b0;

      // arctangent of 2^-i in Q62, one truncated series term at a time
      atan_steps[0] = QUARTER_TURN0;
      for (int i = 1; i < ROT_STEPS; i++) begin
         acc = '0;
         k   = 0;
         e   = 62 - i;
         while (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            acc  = (k % 2 == 1) ? acc - term : acc + term;
            k++;
            e = 62 - i * (2 * k + 1);
         end
         atan_steps[i] = acc;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_corner_samples();
      test_random_samples(1000);
      test_stall_fill(200);
      test_pause_drain(50);

      drain();
      repeat (PIPE_STAGES + 10) @(posedge clock);
      if (fail_count == 0 && pending_polar.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
